// File: rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
package stq_pkg;

  // Default number of timer slots.
  localparam int CAPACITY_DEF = 16;

  // Depth of the command queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Field widths fixed by the interface.
  localparam int HDL_W = 8;
  localparam int EXP_W = 32;

  // Input operation codes.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POST   = 1'b1
  } op_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXPIRED = 2'd1,
    KIND_DONE    = 2'd2
  } kind_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FULL,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_POST_CHK,
    S_POST_POP
  } state_t;

  // Classified command word handed from front to back.
  typedef struct packed {
    op_t              op;
    logic [HDL_W-1:0] handle;
    logic [EXP_W-1:0] expiry;
    logic [EXP_W-1:0] now;
  } cmd_t;

  // One stored timer.
  typedef struct packed {
    logic [HDL_W-1:0] handle;
    logic [EXP_W-1:0] expiry;
  } entry_t;

  // Command hand-off between front and back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

// File: rtl/sorted_timer_queue_top.sv
// Sorted timer queue: front end with command queue, back end with sorted store.
// Insert: each entry later than the new one is read and moved up one slot, and then the new
// timer is written into the hole; an empty store goes straight to the write, a full one to the result.
// Post: each expired timer gives one expired word, head first, followed by a post done word.
// The back end takes one word at a time, and its result words wait on out_ready. Synchronous
// active-low reset empties the store and queue; entry memory contents are not cleared.
module sorted_timer_queue_top
  import stq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [HDL_W-1:0] in_timer_handle,
  input  logic [EXP_W-1:0] in_expiry_time,
  input  logic [EXP_W-1:0] in_current_time,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_result_kind,
  output logic [HDL_W-1:0] out_expired_handle,
  output logic             out_became_head,
  output logic             out_store_full,
  output logic             out_head_valid,
  output logic [EXP_W-1:0] out_head_expiry,
  output logic             out_last_result
);

  cmd_chan_t q_chan;
  logic      q_pop;

  // Accept and classify input words.
  stq_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_timer_handle (in_timer_handle),
    .in_expiry_time  (in_expiry_time),
    .in_current_time (in_current_time),
    .q_out           (q_chan),
    .q_pop           (q_pop)
  );

  // Execute commands against the sorted store.
  stq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_in               (q_chan),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_expired_handle (out_expired_handle),
    .out_became_head    (out_became_head),
    .out_store_full     (out_store_full),
    .out_head_valid     (out_head_valid),
    .out_head_expiry    (out_head_expiry),
    .out_last_result    (out_last_result)
  );

endmodule

// File: rtl/stq_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
module stq_front
  import stq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [HDL_W-1:0] in_timer_handle,
  input  logic [EXP_W-1:0] in_expiry_time,
  input  logic [EXP_W-1:0] in_current_time,
  output cmd_chan_t        q_out,
  input  logic             q_pop
);

  localparam int QCW = $clog2(Q_DEPTH + 1);

  cmd_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [QCW-1:0]  qcnt_r, qcnt_nxt;
  logic            push;
  logic            pop;
  cmd_t            cmd_in;

  // Classify the word; fields an operation ignores are cleared.
  always_comb begin
    cmd_in.op     = op_t'(in_opcode);
    cmd_in.handle = in_timer_handle;
    cmd_in.expiry = in_expiry_time;
    cmd_in.now    = in_current_time;
    if (cmd_in.op == OP_POST) begin
      cmd_in.handle = '0;
      cmd_in.expiry = '0;
    end else begin
      cmd_in.now = '0;
    end
  end

  assign in_ready = (qcnt_r != QCW'(Q_DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && (qcnt_r != '0);

  assign q_out.valid = (qcnt_r != '0);
  assign q_out.cmd   = q_mem_r[rptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    qcnt_nxt = qcnt_r;
    if (push && !pop) begin
      qcnt_nxt = qcnt_r + 1'b1;
    end else if (pop && !push) begin
      qcnt_nxt = qcnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cmd_in;
    end
  end

endmodule

// File: rtl/stq_back.sv
// Back end: keeps the sorted timer store and produces the result words.
module stq_back
  import stq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_chan_t        q_in,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_result_kind,
  output logic [HDL_W-1:0] out_expired_handle,
  output logic             out_became_head,
  output logic             out_store_full,
  output logic             out_head_valid,
  output logic [EXP_W-1:0] out_head_expiry,
  output logic             out_last_result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // Ring of entries; the head sits at head_r and entries follow in order.
  entry_t          mem [CAPACITY];
  entry_t          rd_data_r;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  cmd_t            cmd_r, cmd_nxt;
  entry_t          hcache_r, hcache_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            kind_r, kind_nxt;
  logic [HDL_W-1:0] hdl_r, hdl_nxt;
  logic             bhead_r, bhead_nxt;
  logic             full_r, full_nxt;
  logic             hvalid_r, hvalid_nxt;
  logic [EXP_W-1:0] hexp_r, hexp_nxt;
  logic             last_r, last_nxt;

  logic             can_emit;
  logic [CW-1:0]    cnt_dec;

  // Physical slot of the entry at a given offset from the head.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign can_emit = !out_valid_r || out_ready;
  assign cnt_dec  = cnt_r - 1'b1;

  // Sequencer: next state, store updates and result words.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    head_nxt   = head_r;
    idx_nxt    = idx_r;
    cmd_nxt    = cmd_r;
    hcache_nxt = hcache_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    mem_we     = 1'b0;
    mem_waddr  = head_r;
    mem_wdata  = rd_data_r;

    out_valid_nxt = out_valid_r && !out_ready;
    kind_nxt      = kind_r;
    hdl_nxt       = hdl_r;
    bhead_nxt     = bhead_r;
    full_nxt      = full_r;
    hvalid_nxt    = hvalid_r;
    hexp_nxt      = hexp_r;
    last_nxt      = last_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_in.valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_in.cmd;
          idx_nxt = cnt_r;
          if (q_in.cmd.op == OP_POST) begin
            state_nxt = S_POST_CHK;
          end else if (cnt_r == CW'(CAPACITY)) begin
            state_nxt = S_FULL;
          end else if (cnt_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end

      // Store full: report and drop.
      S_FULL: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_INSERT;
          hdl_nxt       = '0;
          bhead_nxt     = 1'b0;
          full_nxt      = 1'b1;
          hvalid_nxt    = 1'b1;
          hexp_nxt      = hcache_r.expiry;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Fetch the entry just below the hole.
      S_INS_RD: begin
        rd_en     = 1'b1;
        rd_addr   = slot_of(head_r, idx_r - 1'b1);
        state_nxt = S_INS_CMP;
      end

      // A later entry moves up one slot; otherwise the hole is the spot.
      S_INS_CMP: begin
        if (cmd_r.expiry < rd_data_r.expiry) begin
          mem_we    = 1'b1;
          mem_waddr = slot_of(head_r, idx_r);
          mem_wdata = rd_data_r;
          idx_nxt   = idx_r - 1'b1;
          if (idx_r == CW'(1)) begin
            state_nxt = S_INS_PUT;
          end else begin
            state_nxt = S_INS_RD;
          end
        end else begin
          state_nxt = S_INS_PUT;
        end
      end

      // Write the new timer into the hole and report.
      S_INS_PUT: begin
        if (can_emit) begin
          mem_we           = 1'b1;
          mem_waddr        = slot_of(head_r, idx_r);
          mem_wdata.handle = cmd_r.handle;
          mem_wdata.expiry = cmd_r.expiry;
          cnt_nxt          = cnt_r + 1'b1;
          if (idx_r == '0) begin
            hcache_nxt.handle = cmd_r.handle;
            hcache_nxt.expiry = cmd_r.expiry;
          end
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_INSERT;
          hdl_nxt       = '0;
          bhead_nxt     = (idx_r == '0);
          full_nxt      = 1'b0;
          hvalid_nxt    = 1'b1;
          hexp_nxt      = (idx_r == '0) ? cmd_r.expiry : hcache_r.expiry;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Test the head; fetch its successor if it has expired.
      S_POST_CHK: begin
        if ((cnt_r != '0) && (hcache_r.expiry < cmd_r.now)) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(head_r, CW'(1));
          state_nxt = S_POST_POP;
        end else if (can_emit) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_DONE;
          hdl_nxt       = '0;
          bhead_nxt     = 1'b0;
          full_nxt      = 1'b0;
          hvalid_nxt    = (cnt_r != '0);
          hexp_nxt      = (cnt_r != '0) ? hcache_r.expiry : '0;
          last_nxt      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      // Emit the expired head and advance to its successor.
      S_POST_POP: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_EXPIRED;
          hdl_nxt       = hcache_r.handle;
          bhead_nxt     = 1'b0;
          full_nxt      = 1'b0;
          hvalid_nxt    = (cnt_dec != '0);
          hexp_nxt      = (cnt_dec != '0) ? rd_data_r.expiry : '0;
          last_nxt      = 1'b0;
          hcache_nxt    = rd_data_r;
          cnt_nxt       = cnt_dec;
          head_nxt      = slot_of(head_r, CW'(1));
          state_nxt     = S_POST_CHK;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    cmd_r    <= cmd_nxt;
    hcache_r <= hcache_nxt;
    kind_r   <= kind_nxt;
    hdl_r    <= hdl_nxt;
    bhead_r  <= bhead_nxt;
    full_r   <= full_nxt;
    hvalid_r <= hvalid_nxt;
    hexp_r   <= hexp_nxt;
    last_r   <= last_nxt;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_expired_handle = hdl_r;
  assign out_became_head    = bhead_r;
  assign out_store_full     = full_r;
  assign out_head_valid     = hvalid_r;
  assign out_head_expiry    = hexp_r;
  assign out_last_result    = last_r;

endmodule

// File: verif/sorted_timer_queue_top_tb.sv
// Self-checking testbench for the sorted timer queue: a scoreboard predicts every word.
`timescale 1ns / 1ps

module sorted_timer_queue_top_tb;
  import stq_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;

  // One result word as the block reports it.
  typedef struct packed {
    kind_t            kind;
    logic [HDL_W-1:0] handle;
    logic             became_head;
    logic             store_full;
    logic             head_valid;
    logic [EXP_W-1:0] head_expiry;
    logic             last;
  } timer_result_t;

  // Keeps its own sorted copy of the timers and the words they should produce.
  class timer_scoreboard;
    timer_result_t    expected_q[$];
    logic [EXP_W-1:0] slot_expiry[SLOTS];
    logic [HDL_W-1:0] slot_handle[SLOTS];
    int unsigned      pending = 0;
    int unsigned      mismatches = 0;

    // Appends one predicted word behind the ones already waiting.
    function void add_expected(timer_result_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Builds a word whose head is the timer at index first, if it is still pending.
    function timer_result_t make_result(kind_t k, logic [HDL_W-1:0] h, logic bh, logic sf,
                                        int unsigned first, logic last);
      timer_result_t r;
      r.kind        = k;
      r.handle      = h;
      r.became_head = bh;
      r.store_full  = sf;
      r.head_valid  = (first < pending);
      r.head_expiry = (first < pending) ? slot_expiry[first] : '0;
      r.last        = last;
      return r;
    endfunction

    // Applies one accepted input word and queues the words it should cause.
    function void note_word(op_t op, logic [HDL_W-1:0] h, logic [EXP_W-1:0] expiry,
                            logic [EXP_W-1:0] now);
      int unsigned pos;
      int unsigned cut;
      int unsigned i;
      if (op == OP_INSERT) begin
        if (pending >= SLOTS) begin
          add_expected(make_result(KIND_INSERT, '0, 1'b0, 1'b1, 0, 1'b1));
          return;
        end
        // Equal expiries go behind the ones already stored.
        pos = 0;
        while (pos < pending && !(expiry < slot_expiry[pos])) pos++;
        for (i = pending; i > pos; i--) begin
          slot_expiry[i] = slot_expiry[i-1];
          slot_handle[i] = slot_handle[i-1];
        end
        slot_expiry[pos] = expiry;
        slot_handle[pos] = h;
        pending++;
        add_expected(make_result(KIND_INSERT, '0, pos == 0, 1'b0, 0, 1'b1));
        return;
      end
      // Expired timers are a prefix of the sorted store; equal to now is not expired.
      cut = 0;
      while (cut < pending && slot_expiry[cut] < now) cut++;
      for (i = 0; i < cut; i++)
        add_expected(make_result(KIND_EXPIRED, slot_handle[i], 1'b0, 1'b0, i + 1, 1'b0));
      for (i = cut; i < pending; i++) begin
        slot_expiry[i-cut] = slot_expiry[i];
        slot_handle[i-cut] = slot_handle[i];
      end
      pending -= cut;
      add_expected(make_result(KIND_DONE, '0, 1'b0, 1'b0, 0, 1'b1));
    endfunction

    function string describe(timer_result_t r);
      return $sformatf({"kind=%0d handle=%02h became_head=%0b full=%0b ",
                        "head_valid=%0b head=%08h last=%0b"},
                       r.kind, r.handle, r.became_head, r.store_full, r.head_valid,
                       r.head_expiry, r.last);
    endfunction

    function void flag(string why, timer_result_t want, timer_result_t seen);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch (%s): expected %s\n  got      %s", why, describe(want),
                 describe(seen));
    endfunction

    // Compares one accepted result word with the oldest prediction.
    function void check_result(timer_result_t seen);
      timer_result_t want;
      if (expected_q.size() == 0) begin
        flag("no word expected", '0, seen);
        return;
      end
      want = expected_q.pop_front();
      if (seen.kind !== want.kind || seen.handle !== want.handle ||
          seen.became_head !== want.became_head || seen.store_full !== want.store_full ||
          seen.head_valid !== want.head_valid || seen.head_expiry !== want.head_expiry ||
          seen.last !== want.last)
        flag("field differs", want, seen);
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_opcode;
  logic [HDL_W-1:0] in_timer_handle;
  logic [EXP_W-1:0] in_expiry_time;
  logic [EXP_W-1:0] in_current_time;
  logic             out_valid;
  logic             out_ready;
  logic [1:0]       out_result_kind;
  logic [HDL_W-1:0] out_expired_handle;
  logic             out_became_head;
  logic             out_store_full;
  logic             out_head_valid;
  logic [EXP_W-1:0] out_head_expiry;
  logic             out_last_result;

  timer_scoreboard  sb = new;
  timer_result_t    seen;
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               insert_pct = 60;
  int               hold_left = 0;
  bit               hold_req = 1'b0;
  logic [EXP_W-1:0] tick_base;
  logic [EXP_W-1:0] last_expiry;

  sorted_timer_queue_top #(.CAPACITY(SLOTS)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_timer_handle    (in_timer_handle),
    .in_expiry_time     (in_expiry_time),
    .in_current_time    (in_current_time),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_expired_handle (out_expired_handle),
    .out_became_head    (out_became_head),
    .out_store_full     (out_store_full),
    .out_head_valid     (out_head_valid),
    .out_head_expiry    (out_head_expiry),
    .out_last_result    (out_last_result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off once it is requested.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: note accepted input words, then check accepted result words.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_word(op_t'(in_opcode), in_timer_handle, in_expiry_time, in_current_time);
      if (out_valid && out_ready) begin
        seen.kind        = kind_t'(out_result_kind);
        seen.handle      = out_expired_handle;
        seen.became_head = out_became_head;
        seen.store_full  = out_store_full;
        seen.head_valid  = out_head_valid;
        seen.head_expiry = out_head_expiry;
        seen.last        = out_last_result;
        sb.check_result(seen);
      end
    end
  end

  // Offers one word after a random idle gap and waits until it is taken.
  task automatic send_word(input op_t op, input logic [HDL_W-1:0] h,
                           input logic [EXP_W-1:0] expiry, input logic [EXP_W-1:0] now);
    int gap;
    gap = 0;
    while (gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_timer_handle <= h;
    in_expiry_time  <= expiry;
    in_current_time <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic insert_timer(input logic [HDL_W-1:0] h, input logic [EXP_W-1:0] expiry);
    send_word(OP_INSERT, h, expiry, $urandom());
  endtask

  task automatic post_time(input logic [EXP_W-1:0] now);
    send_word(OP_POST, HDL_W'($urandom_range(255)), $urandom(), now);
  endtask

  // Random traffic around a moving tick, with some wild values mixed in.
  task automatic random_word();
    int pick;
    logic [EXP_W-1:0] value;
    if ($urandom_range(19) == 0) insert_pct = $urandom_range(40, 85);
    pick = $urandom_range(99);
    if ($urandom_range(99) < insert_pct) begin
      if (pick < 70)      value = tick_base + $urandom_range(300);
      else if (pick < 82) value = last_expiry;
      else                value = $urandom();
      last_expiry = value;
      insert_timer(HDL_W'($urandom_range(255)), value);
    end else begin
      if (pick < 75) begin
        value = tick_base + $urandom_range(300);
        tick_base = tick_base + $urandom_range(150);
      end else if (pick < 85) begin
        value = '0;
      end else if (pick < 95) begin
        value = $urandom();
      end else begin
        value = '1;
      end
      post_time(value);
    end
  endtask

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int i;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_opcode       <= OP_INSERT;
    in_timer_handle <= '0;
    in_expiry_time  <= '0;
    in_current_time <= '0;
    out_ready       <= 1'b0;
    tick_base       = $urandom();
    last_expiry     = tick_base;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty post, extremes, equal expiries, full store, longest post.
    post_time('1);
    insert_timer(8'h00, 32'h0000_0000);
    insert_timer(8'hFF, 32'hFFFF_FFFE);
    insert_timer(8'h01, 32'd100);
    insert_timer(8'h02, 32'd100);
    insert_timer(8'h03, 32'd100);
    post_time(32'd100);
    for (i = 0; i < 12; i++)
      insert_timer(HDL_W'(8'h10 + i), EXP_W'(1000 - 50 * i));
    insert_timer(8'hAA, 32'h5555_5555);
    post_time('1);
    insert_timer(8'h55, 32'hFFFF_FFFF);
    post_time('1);
    post_time('0);

    // The receiver holds off while the sender keeps offering, so the block backs up.
    hold_req = 1'b1;
    for (i = 0; i < 30; i++) random_word();

    // Random phases with different idle and stall mixes.
    for (i = 0; i < 4; i++) begin
      case (i)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      repeat (105) random_word();
    end
    in_valid <= 1'b0;

    // Drain, then allow for any late stray word.
    while (sb.waiting() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
